// File: rtl/core/arp_cache_table_defines.svh
// Assertion helpers for the ARP cache core.
// Every check is clocked on i_clk and held off while i_rst_n is low.
`ifndef ARP_CACHE_TABLE_DEFINES_SVH
`define ARP_CACHE_TABLE_DEFINES_SVH

// Same-cycle check: the consequent must hold whenever the antecedent does.
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle check: the consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/arpc_pkg.sv
package arpc_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int CNT_W = 3;

    // Operation codes carried on i_kind.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_entry;

endpackage

// File: rtl/core/arp_cache_table.sv
// Channel | Dir | Handshake                 | Beat payload
// --------+-----+---------------------------+----------------------------------
// in      | in  | i_in_valid / o_in_stall   | i_kind, i_ip_addr, i_mac_addr
// out     | out | o_out_valid / i_out_stall | o_hit, o_found_mac, o_entry_count
//
// One beat in at a time. Lookup: scan from the oldest entry to a hit or the end.
// Insert: scan, then compact one entry per cycle over the matched or evicted
// slot through the entry memory (one read, one write port), or append.
// Synchronous active-low reset empties the table (count to 0), not the memory.
// A result parks in the output register under i_out_stall; the next beat is
// taken meanwhile and its result waits in S_OUT.
`include "arp_cache_table_defines.svh"

module arp_cache_table #(
    parameter int CACHE_ENTRIES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_kind,
    input  logic [arpc_pkg::IP_W-1:0]   i_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]  i_mac_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [arpc_pkg::MAC_W-1:0]  o_found_mac,
    output logic [arpc_pkg::CNT_W-1:0]  o_entry_count
);
    import arpc_pkg::*;

    // AW: entry index width, CW: count width (holds CACHE_ENTRIES itself).
    localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_APPEND,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;       // entry under compare / write target
    logic               r_kind;
    logic [IP_W-1:0]    r_ip;
    logic [MAC_W-1:0]   r_mac;
    logic               r_hit;
    logic [MAC_W-1:0]   r_found;

    logic               r_out_valid;
    logic               r_out_hit;
    logic [MAC_W-1:0]   r_out_mac;
    logic [CNT_W-1:0]   r_out_cnt;

    // Entry memory, oldest entry at index 0.
    t_entry             r_mem [CACHE_ENTRIES];
    t_entry             r_rd_data;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    t_entry             mem_wdata;

    logic [CW-1:0]      idx_nxt;
    logic               last;        // r_idx is the youngest valid entry
    logic               match;
    logic               full;
    logic               out_free;
    logic               out_load;
    logic               in_accept;

    assign idx_nxt   = CW'(r_idx) + CW'(1);
    assign last      = (idx_nxt == r_count);
    assign match     = (r_rd_data.ip == r_ip);
    assign full      = (r_count == CW'(CACHE_ENTRIES));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = (r_state == S_OUT) && out_free;
    assign in_accept = i_in_valid && (r_state == S_IDLE);

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_found_mac   = r_out_mac;
    assign o_entry_count = r_out_cnt;

    // Memory port control. Reads run one entry ahead of the compare/write
    // index; compaction copies k+1 into k and reads k+2 (never the same row).
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_raddr = r_idx + AW'(1);
        mem_wdata = '{ip: r_ip, mac: r_mac};
        unique case (r_state)
            S_IDLE: begin
                mem_raddr = '0;
            end
            S_SCAN: begin
                // Full table, no match: restart reads at 1 for the eviction.
                if (!match && last) begin
                    mem_raddr = AW'(1);
                end
            end
            S_SHIFT: begin
                mem_we = 1'b1;
                if (!last) begin
                    mem_wdata = r_rd_data;
                    mem_raddr = r_idx + AW'(1) + AW'(1);
                end
            end
            S_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_count);
            end
            S_OUT: begin
                mem_raddr = '0;
            end
            default: begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result replaces the held one only once it has left.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_kind  <= i_kind;
                        r_ip    <= i_ip_addr;
                        r_mac   <= i_mac_addr;
                        r_hit   <= 1'b0;
                        r_found <= '0;
                        r_idx   <= '0;
                        if (r_count == '0) begin
                            r_state <= (i_kind == KIND_INSERT) ? S_APPEND : S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        // Lowest index wins; an insert closes the gap from here.
                        r_hit <= 1'b1;
                        if (r_kind == KIND_LOOKUP) begin
                            r_found <= r_rd_data.mac;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end else if (last) begin
                        if (r_kind == KIND_LOOKUP) begin
                            r_state <= S_OUT;
                        end else if (full) begin
                            r_idx   <= '0;      // evict the oldest
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_APPEND;
                        end
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_SHIFT: begin
                    // The last write drops the new pair into the youngest
                    // slot, so the count is unchanged (one out, one in).
                    if (!last) begin
                        r_idx <= r_idx + AW'(1);
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_APPEND: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_hit   <= r_hit;
                        r_out_mac   <= r_found;
                        r_out_cnt   <= CNT_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ARPC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CACHE_ENTRIES),
        "entry count above table size")
    `ARPC_ASSERT_NOW(a_shift_in_range, r_state == S_SHIFT, CW'(r_idx) < r_count,
        "compaction index outside valid entries")
    `ARPC_ASSERT_NEXT(a_count_only_on_append, r_state != S_APPEND, $stable(r_count),
        "entry count changed outside append")
    `ARPC_ASSERT_NOW(a_mac_only_on_hit, o_out_valid && !o_hit, o_found_mac == '0,
        "nonzero MAC on a result without hit")

endmodule

// File: tb/arp_cache_checker.sv
module arp_cache_checker #(
    parameter int CACHE_ENTRIES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_kind,
    input  logic [arpc_pkg::IP_W-1:0]   i_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]  i_mac_addr,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_hit,
    input  logic [arpc_pkg::MAC_W-1:0]  i_found_mac,
    input  logic [arpc_pkg::CNT_W-1:0]  i_entry_count,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] found_mac;
        logic [CNT_W-1:0] entry_count;
    } t_arp_reply;

    // Shadow of the cache, oldest entry at index 0.
    logic [IP_W-1:0]  shadow_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0] shadow_mac [CACHE_ENTRIES];
    int               shadow_count = 0;

    t_arp_reply replies_due[$];
    int         mismatches = 0;

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < shadow_count; k++) begin
            shadow_ip[k]  = shadow_ip[k + 1];
            shadow_mac[k] = shadow_mac[k + 1];
        end
        shadow_count--;
    endfunction

    function automatic t_arp_reply resolve_arp(logic kind, logic [IP_W-1:0] ip,
                                               logic [MAC_W-1:0] mac);
        t_arp_reply reply;
        reply = '0;
        if (kind == KIND_INSERT) begin
            for (int i = 0; i < shadow_count; i++) begin
                if (shadow_ip[i] == ip) begin
                    drop_entry(i);
                    reply.hit = 1'b1;
                    break;
                end
            end
            if (shadow_count >= CACHE_ENTRIES) drop_entry(0);
            shadow_ip[shadow_count]  = ip;
            shadow_mac[shadow_count] = mac;
            shadow_count++;
        end else begin
            for (int i = 0; i < shadow_count; i++) begin
                if (shadow_ip[i] == ip) begin
                    reply.hit       = 1'b1;
                    reply.found_mac = shadow_mac[i];
                    break;
                end
            end
        end
        reply.entry_count = CNT_W'(shadow_count);
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_arp_reply want;
        if (!i_rst_n) begin
            shadow_count = 0;
            replies_due.delete();
        end else begin
            // retire the output beat first so a same-edge request can't match it
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("unrequested result: hit=%0b found_mac=%h entry_count=%0d",
                           i_hit, i_found_mac, i_entry_count);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_hit !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, i_hit);
                        mismatches++;
                    end
                    if (i_found_mac !== want.found_mac) begin
                        $error("found_mac: expected %h, got %h", want.found_mac, i_found_mac);
                        mismatches++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, i_entry_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                replies_due.push_back(resolve_arp(i_kind, i_ip_addr, i_mac_addr));
        end
        o_fail_count <= mismatches;
        o_pending    <= replies_due.size();
    end

endmodule

// File: tb/arp_cache_table_tb.sv
module arp_cache_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam int CACHE_ENTRIES = 4;
    localparam int RUN_ITEMS     = 850;
    // A beat's worst-case work plus sender gap and receiver stall tails, over
    // ~900 beats, stay far below this.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int POOL_MAX      = 6;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_kind        = KIND_INSERT;
    logic [IP_W-1:0]    i_ip_addr     = '0;
    logic [MAC_W-1:0]   i_mac_addr    = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic               o_hit;
    logic [MAC_W-1:0]   o_found_mac;
    logic [CNT_W-1:0]   o_entry_count;

    int fail_count;
    int replies_pending;
    int cycle_count = 0;

    // Address pool for the random part: a handful of IPs reused so that
    // lookups hit, inserts replace, and a pool wider than the table evicts.
    logic [IP_W-1:0] ip_pool [POOL_MAX];
    int              pool_used;

    always #5 i_clk = ~i_clk;

    arp_cache_table #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_ip_addr     (i_ip_addr),
        .i_mac_addr    (i_mac_addr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_found_mac   (o_found_mac),
        .o_entry_count (o_entry_count)
    );

    arp_cache_checker #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_ip_addr     (i_ip_addr),
        .i_mac_addr    (i_mac_addr),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_hit         (o_hit),
        .i_found_mac   (o_found_mac),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (replies_pending)
    );

    // Receiver back-pressure. Runs in phases of random length: no stall at
    // all, light random stalls, or heavy stalls that park results in the
    // output register while the block takes the next beat.
    int stall_mode = 0;
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(5, 80);
            end
            stall_left--;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 2) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Present one request beat and hold it until the block takes it. Valid
    // is left high so back-to-back beats never drop it within one step.
    task automatic send_arp(input logic kind, input logic [IP_W-1:0] ip,
                            input logic [MAC_W-1:0] mac);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_ip_addr  <= ip;
        i_mac_addr <= mac;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Sender gap with valid low.
    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending until every outstanding result has been delivered.
    task automatic hold_until_drained();
        idle_sender(1);
        while (replies_pending != 0) @(posedge i_clk);
    endtask

    // New pool: random IPs, the all-zero and all-one addresses now and then,
    // and one-bit neighbors of other entries so that near misses show up.
    task automatic refresh_pool();
        pool_used = $urandom_range(2, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++) begin
            case ($urandom_range(0, 9))
                0:       ip_pool[i] = '0;
                1:       ip_pool[i] = '1;
                2, 3:    ip_pool[i] = (i == 0) ? $urandom
                                     : ip_pool[i - 1] ^ (IP_W'(1) << $urandom_range(0, IP_W - 1));
                default: ip_pool[i] = $urandom;
            endcase
        end
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return raw[MAC_W-1:0];
        endcase
    endfunction

    initial begin
        int burst_left;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-table miss, extreme IP/MAC values, replace of an
        // existing IP, fill to capacity, eviction of the oldest entry,
        // replace while full (no eviction), misses on a full table.
        send_arp(KIND_LOOKUP, 32'h0000_0000, '1);
        send_arp(KIND_INSERT, 32'h0000_0000, 48'h0000_0000_0000);
        send_arp(KIND_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_arp(KIND_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_arp(KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
        send_arp(KIND_INSERT, 32'h0000_0000, 48'h5555_5555_5555);
        send_arp(KIND_INSERT, 32'h0A00_0001, 48'hAAAA_AAAA_AAAA);
        send_arp(KIND_INSERT, 32'hC0A8_0001, 48'h0123_4567_89AB);
        send_arp(KIND_LOOKUP, 32'hC0A8_0001, 48'h0);
        send_arp(KIND_INSERT, 32'h0808_0808, 48'hFEDC_BA98_7654);
        send_arp(KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        send_arp(KIND_LOOKUP, 32'h0808_0808, 48'h0);
        send_arp(KIND_LOOKUP, 32'h0000_0000, 48'h0);
        send_arp(KIND_INSERT, 32'h0A00_0001, 48'h8000_0000_0001);
        send_arp(KIND_LOOKUP, 32'h0A00_0001, 48'h0);
        send_arp(KIND_LOOKUP, 32'h0A00_0000, 48'h0);
        send_arp(KIND_LOOKUP, 32'h1234_5678, 48'h0);
        send_arp(KIND_INSERT, 32'h8000_0000, 48'h7FFF_FFFF_FFFE);
        send_arp(KIND_LOOKUP, 32'h0000_0000, 48'h0);
        send_arp(KIND_LOOKUP, 32'h8000_0000, 48'h0);
        hold_until_drained();

        // Random part: bursts of beats separated by random gaps (zero gaps
        // give long unbroken stretches). Mostly pool traffic, some random IPs.
        refresh_pool();
        burst_left = 0;
        for (int n = 0; n < RUN_ITEMS; n++) begin
            logic            kind;
            logic [IP_W-1:0] ip;
            if (burst_left == 0) begin
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
            if (n % 60 == 59) refresh_pool();
            kind = ($urandom_range(0, 99) < 50) ? KIND_INSERT : KIND_LOOKUP;
            if ($urandom_range(0, 9) == 0) ip = $urandom;
            else                           ip = ip_pool[$urandom_range(0, pool_used - 1)];
            send_arp(kind, ip, random_mac());
            if (n % 200 == 199) hold_until_drained();
        end

        hold_until_drained();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/arpc_pkg.sv
rtl/core/arp_cache_table.sv
tb/arp_cache_checker.sv
tb/arp_cache_table_tb.sv
